@@ rtl/accel_tilt_angles_defines.svh @@
// ---------------------------------------------------------------------------
// Tilt angle accelerator: assertion macros
// Shared property macros for the checker of the tilt angle pipeline.
// ---------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLES_DEFINES_SVH
`define ACCEL_TILT_ANGLES_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ATA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ATA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define ATA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ata_pkg.sv @@
// ---------------------------------------------------------------------------
// Tilt angle accelerator: shared package
// Widths, constants, beat types and the arctangent table of the CORDIC.
// ---------------------------------------------------------------------------
package ata_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int MAX_STAGES        = 24;

   localparam int IN_W       = 16;
   localparam int SCALE_BITS = 12;
   localparam int RAD_W      = 32;
   localparam int SQRT_STEPS = RAD_W / 2 + SCALE_BITS;
   localparam int ROOT_W     = SQRT_STEPS;
   localparam int REM_W      = ROOT_W + 2;
   localparam int SQ_WORK_W  = REM_W + 2;

   localparam int CV_W      = 31;
   localparam int ACC_W     = 26;
   localparam int ATAN_W    = 22;
   localparam int OUT_SHIFT = 9;
   localparam int R_W       = ACC_W - OUT_SHIFT;
   localparam int PITCH_W   = 15;
   localparam int ROLL_W    = 16;

   localparam logic signed [ACC_W-1:0] DEG180_Q16 = 26'sd11796480;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = 26'sd256;
   localparam logic signed [R_W-1:0]   PITCH_LIMIT = 17'sd11520;
   localparam logic signed [R_W-1:0]   ROLL_LIMIT  = 17'sd23040;

   typedef enum logic [1:0] {
      SPEC_NONE    = 2'd0,
      SPEC_ZERO    = 2'd1,
      SPEC_NEG_LIM = 2'd2
   } spec_type;

   typedef struct packed {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
   } axes_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic signed [CV_W-1:0]  xv;
      logic signed [CV_W-1:0]  yv;
      logic signed [ACC_W-1:0] acc;
      spec_type                spec;
   } vec_type;

   // atan(2^-idx) in degrees, scaled by 2^16 and rounded to nearest.
   function automatic logic [ATAN_W-1:0] atan_q16(input int unsigned idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         0:  v = 22'd2949120;
         1:  v = 22'd1740967;
         2:  v = 22'd919879;
         3:  v = 22'd466945;
         4:  v = 22'd234379;
         5:  v = 22'd117304;
         6:  v = 22'd58666;
         7:  v = 22'd29335;
         8:  v = 22'd14668;
         9:  v = 22'd7334;
         10: v = 22'd3667;
         11: v = 22'd1833;
         12: v = 22'd917;
         13: v = 22'd458;
         14: v = 22'd229;
         15: v = 22'd115;
         16: v = 22'd57;
         17: v = 22'd29;
         18: v = 22'd14;
         19: v = 22'd7;
         20: v = 22'd4;
         21: v = 22'd2;
         22: v = 22'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/ata_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// Tilt angle accelerator: square root cell
// One step of a digit-by-digit integer square root, carrying the sample along.
// ---------------------------------------------------------------------------
module ata_sqrt_cell (
   input  logic              clock,
   input  logic              load,
   input  ata_pkg::sq_type   sq_i,
   input  ata_pkg::axes_type axes_i,
   output ata_pkg::sq_type   sq_o,
   output ata_pkg::axes_type axes_o
);

   localparam int PAD_W = ata_pkg::SQ_WORK_W - ata_pkg::ROOT_W - 2;

   ata_pkg::sq_type   sq_ff, sq_in;
   ata_pkg::axes_type axes_ff;

   logic [ata_pkg::SQ_WORK_W-1:0] work, trial, diff;
   logic                          fits;

   // Bring down the next two radicand bits and try the next root bit.
   always_comb begin
      work  = {sq_i.rem, sq_i.rad[ata_pkg::RAD_W-1 -: 2]};
      trial = {{PAD_W{1'b0}}, sq_i.root, 2'b01};
      diff  = work - trial;
      fits  = (work >= trial);
      sq_in.rem  = fits ? diff[ata_pkg::REM_W-1:0] : work[ata_pkg::REM_W-1:0];
      sq_in.root = {sq_i.root[ata_pkg::ROOT_W-2:0], fits};
      sq_in.rad  = {sq_i.rad[ata_pkg::RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff   <= sq_in;
         axes_ff <= axes_i;
      end
   end

   assign sq_o   = sq_ff;
   assign axes_o = axes_ff;

endmodule

@@ rtl/ata_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// Tilt angle accelerator: CORDIC cell
// One vectoring micro-rotation with its fixed shift and arctangent step.
// ---------------------------------------------------------------------------
module ata_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic             clock,
   input  logic             load,
   input  ata_pkg::vec_type vec_i,
   output ata_pkg::vec_type vec_o
);

   localparam logic signed [ata_pkg::ACC_W-1:0] ATAN_STEP =
      $signed({{(ata_pkg::ACC_W - ata_pkg::ATAN_W){1'b0}}, ata_pkg::atan_q16(STAGE)});

   ata_pkg::vec_type vec_ff, vec_in;

   logic signed [ata_pkg::CV_W-1:0]  xs, ys, dx, dy;
   logic signed [ata_pkg::ACC_W-1:0] acc_s;

   always_comb begin
      xs    = vec_i.xv;
      ys    = vec_i.yv;
      acc_s = vec_i.acc;
      dx    = ys >>> STAGE;
      dy    = xs >>> STAGE;
      vec_in = vec_i;
      // Rotate toward the x axis; the sign of y picks the direction.
      if (!ys[ata_pkg::CV_W-1]) begin
         vec_in.xv  = xs + dx;
         vec_in.yv  = ys - dy;
         vec_in.acc = acc_s + ATAN_STEP;
      end else begin
         vec_in.xv  = xs - dx;
         vec_in.yv  = ys + dy;
         vec_in.acc = acc_s - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vec_ff <= vec_in;
      end
   end

   assign vec_o = vec_ff;

endmodule

@@ rtl/accel_tilt_angles.sv @@
// ---------------------------------------------------------------------------
// Tilt angle accelerator: top level
// Pitch and roll in 1/128 degree from one raw three-axis accelerometer beat.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------
//  req      | in        | req_valid / req_stall | req_accel_x, _y, _z (s16)
//  rsp      | out       | rsp_valid / rsp_stall | rsp_pitch_angle (s15),
//           |           |                       | rsp_roll_angle (s16)
//
// One beat enters per cycle while req_stall is low.
// Stages in order: capture, square, sum, 28 square root cells, setup,
// CORDIC_STAGES rotation cells (capped at MAX_STAGES) and output.
// Each stage moves whenever it or any later stage is empty, so bubbles close up
// under rsp_stall and req_stall rises only when every stage holds a beat.
// Synchronous reset clears the stage valid bits.
// ---------------------------------------------------------------------------
module accel_tilt_angles #(
   parameter int CORDIC_STAGES = ata_pkg::CORDIC_STAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [ata_pkg::IN_W-1:0]   req_accel_x,
   input  logic signed [ata_pkg::IN_W-1:0]   req_accel_y,
   input  logic signed [ata_pkg::IN_W-1:0]   req_accel_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ata_pkg::PITCH_W-1:0] rsp_pitch_angle,
   output logic signed [ata_pkg::ROLL_W-1:0]  rsp_roll_angle
);

   localparam int NUM_ROT   = (CORDIC_STAGES < ata_pkg::MAX_STAGES) ?
                              CORDIC_STAGES : ata_pkg::MAX_STAGES;
   localparam int SLOT_IN   = 0;
   localparam int SLOT_SQ   = 1;
   localparam int SLOT_SUM  = 2;
   localparam int SQRT_BASE = 3;
   localparam int SLOT_PREP = SQRT_BASE + ata_pkg::SQRT_STEPS;
   localparam int ROT_BASE  = SLOT_PREP + 1;
   localparam int SLOT_OUT  = ROT_BASE + NUM_ROT;
   localparam int NSLOT     = SLOT_OUT + 1;
   localparam int SQ_W      = 2 * ata_pkg::IN_W - 1;
   localparam int EXT_W     = ata_pkg::CV_W - ata_pkg::IN_W - ata_pkg::SCALE_BITS;

   // Stage occupancy and load enables.
   logic [NSLOT-1:0] valid_ff, valid_in, ready, bubble;

   assign bubble = ~valid_ff;

   for (genvar k = 0; k < NSLOT; k++) begin : g_ready
      assign ready[k] = ~rsp_stall | (|bubble[NSLOT-1:k]);
   end

   always_comb begin
      valid_in[SLOT_IN] = ready[SLOT_IN] ? req_valid : valid_ff[SLOT_IN];
      for (int k = 1; k < NSLOT; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = ~ready[SLOT_IN];
   assign rsp_valid = valid_ff[SLOT_OUT];

   // Capture, square and sum.
   ata_pkg::axes_type      axes_s0_ff, axes_s1_ff, axes_s2_ff;
   logic [SQ_W-1:0]        xsq_ff, zsq_ff;
   logic [ata_pkg::RAD_W-1:0] sumsq_ff;
   logic signed [2*ata_pkg::IN_W-1:0] xprod, zprod;

   assign xprod = axes_s0_ff.x * axes_s0_ff.x;
   assign zprod = axes_s0_ff.z * axes_s0_ff.z;

   always_ff @(posedge clock) begin
      if (ready[SLOT_IN]) begin
         axes_s0_ff <= '{x: req_accel_x, y: req_accel_y, z: req_accel_z};
      end
      if (ready[SLOT_SQ]) begin
         axes_s1_ff <= axes_s0_ff;
         xsq_ff     <= xprod[SQ_W-1:0];
         zsq_ff     <= zprod[SQ_W-1:0];
      end
      if (ready[SLOT_SUM]) begin
         axes_s2_ff <= axes_s1_ff;
         sumsq_ff   <= {1'b0, xsq_ff} + {1'b0, zsq_ff};
      end
   end

   // Square root chain: floor(sqrt(sumsq * 2^24)).
   ata_pkg::sq_type   sq_chain   [0:ata_pkg::SQRT_STEPS];
   ata_pkg::axes_type axes_chain [0:ata_pkg::SQRT_STEPS];

   assign sq_chain[0]   = '{rad: sumsq_ff, rem: '0, root: '0};
   assign axes_chain[0] = axes_s2_ff;

   for (genvar j = 0; j < ata_pkg::SQRT_STEPS; j++) begin : g_sqrt
      ata_sqrt_cell u_cell (
         .clock  (clock),
         .load   (ready[SQRT_BASE + j]),
         .sq_i   (sq_chain[j]),
         .axes_i (axes_chain[j]),
         .sq_o   (sq_chain[j+1]),
         .axes_o (axes_chain[j+1])
      );
   end

   // Vector setup: zero numerator cases and the half turn for a negative
   // denominator.
   function automatic ata_pkg::vec_type vec_prep(
      input logic signed [ata_pkg::CV_W-1:0] num,
      input logic signed [ata_pkg::CV_W-1:0] den
   );
      ata_pkg::vec_type v;
      v.xv   = den;
      v.yv   = num;
      v.acc  = '0;
      v.spec = ata_pkg::SPEC_NONE;
      if (num == '0) begin
         v.spec = den[ata_pkg::CV_W-1] ? ata_pkg::SPEC_NEG_LIM : ata_pkg::SPEC_ZERO;
      end else if (den[ata_pkg::CV_W-1]) begin
         v.acc = num[ata_pkg::CV_W-1] ? -ata_pkg::DEG180_Q16 : ata_pkg::DEG180_Q16;
         v.xv  = -den;
         v.yv  = -num;
      end
      return v;
   endfunction

   ata_pkg::axes_type              axes_last;
   logic signed [ata_pkg::CV_W-1:0] pit_num, pit_den, rol_num, rol_den;
   ata_pkg::vec_type               pit_prep_ff, rol_prep_ff;

   assign axes_last = axes_chain[ata_pkg::SQRT_STEPS];
   assign pit_num = $signed({{EXT_W{axes_last.y[ata_pkg::IN_W-1]}}, axes_last.y,
                             {ata_pkg::SCALE_BITS{1'b0}}});
   assign pit_den = $signed({{(ata_pkg::CV_W - ata_pkg::ROOT_W){1'b0}},
                             sq_chain[ata_pkg::SQRT_STEPS].root});
   assign rol_num = -$signed({{EXT_W{axes_last.x[ata_pkg::IN_W-1]}}, axes_last.x,
                              {ata_pkg::SCALE_BITS{1'b0}}});
   assign rol_den = $signed({{EXT_W{axes_last.z[ata_pkg::IN_W-1]}}, axes_last.z,
                             {ata_pkg::SCALE_BITS{1'b0}}});

   always_ff @(posedge clock) begin
      if (ready[SLOT_PREP]) begin
         pit_prep_ff <= vec_prep(pit_num, pit_den);
         rol_prep_ff <= vec_prep(rol_num, rol_den);
      end
   end

   // Two CORDIC chains side by side, one for each angle.
   ata_pkg::vec_type pit_chain [0:NUM_ROT];
   ata_pkg::vec_type rol_chain [0:NUM_ROT];

   assign pit_chain[0] = pit_prep_ff;
   assign rol_chain[0] = rol_prep_ff;

   for (genvar i = 0; i < NUM_ROT; i++) begin : g_rot
      ata_cordic_cell #(.STAGE(i)) u_pitch (
         .clock (clock),
         .load  (ready[ROT_BASE + i]),
         .vec_i (pit_chain[i]),
         .vec_o (pit_chain[i+1])
      );
      ata_cordic_cell #(.STAGE(i)) u_roll (
         .clock (clock),
         .load  (ready[ROT_BASE + i]),
         .vec_i (rol_chain[i]),
         .vec_o (rol_chain[i+1])
      );
   end

   // Round to 1/128 degree with halves going up, then saturate.
   function automatic logic signed [ata_pkg::R_W-1:0] round_sat(
      input ata_pkg::vec_type               v,
      input logic signed [ata_pkg::R_W-1:0] lim
   );
      logic signed [ata_pkg::ACC_W-1:0] acc_s, sum;
      logic signed [ata_pkg::R_W-1:0]   r, r_sat;
      acc_s = v.acc;
      sum   = acc_s + ata_pkg::ROUND_HALF;
      r     = $signed(sum[ata_pkg::ACC_W-1:ata_pkg::OUT_SHIFT]);
      if (r > lim) begin
         r_sat = lim;
      end else if (r < -lim) begin
         r_sat = -lim;
      end else begin
         r_sat = r;
      end
      case (v.spec)
         ata_pkg::SPEC_NONE:    r = r_sat;
         ata_pkg::SPEC_ZERO:    r = '0;
         ata_pkg::SPEC_NEG_LIM: r = -lim;
         default:               r = '0;
      endcase
      return r;
   endfunction

   logic signed [ata_pkg::R_W-1:0]     pitch_r, roll_r;
   logic signed [ata_pkg::PITCH_W-1:0] pitch_ff;
   logic signed [ata_pkg::ROLL_W-1:0]  roll_ff;

   assign pitch_r = round_sat(pit_chain[NUM_ROT], ata_pkg::PITCH_LIMIT);
   assign roll_r  = round_sat(rol_chain[NUM_ROT], ata_pkg::ROLL_LIMIT);

   always_ff @(posedge clock) begin
      if (ready[SLOT_OUT]) begin
         pitch_ff <= pitch_r[ata_pkg::PITCH_W-1:0];
         roll_ff  <= roll_r[ata_pkg::ROLL_W-1:0];
      end
   end

   assign rsp_pitch_angle = pitch_ff;
   assign rsp_roll_angle  = roll_ff;

endmodule

@@ rtl/ata_checker.sv @@
// ---------------------------------------------------------------------------
// Tilt angle accelerator: port checker
// Concurrent assertions on the top level's ports, attached by bind.
// ---------------------------------------------------------------------------
`include "accel_tilt_angles_defines.svh"

module ata_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [ata_pkg::PITCH_W-1:0] rsp_pitch_angle,
   input logic signed [ata_pkg::ROLL_W-1:0]  rsp_roll_angle
);

   // A stalled result beat stays offered.
   `ATA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp_valid dropped while stalled")

   // A stalled result beat keeps its payload.
   `ATA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_pitch_angle) && $stable(rsp_roll_angle), "rsp payload changed while stalled")

   // The pipeline never pushes back on the input while the output drains.
   `ATA_ASSERT_NOW(a_no_stall_when_draining, clock, reset, !rsp_stall, !req_stall, "req_stall high while rsp side is not stalled")

   // Reset empties the pipeline.
   `ATA_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "rsp_valid high after reset")

endmodule

bind accel_tilt_angles ata_checker u_ata_checker (.*);

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// Tilt angle accelerator: self-checking testbench
// Drives raw accelerometer samples into the pipeline with random gaps and
// random back-pressure, predicts pitch and roll with an integer CORDIC of its
// own, and checks every result beat in order against that prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int    IN_W           = ata_pkg::IN_W;
   localparam int    PITCH_W        = ata_pkg::PITCH_W;
   localparam int    ROLL_W         = ata_pkg::ROLL_W;
   localparam int    ATAN_ENTRIES   = 24;
   localparam int    ROTATIONS      = (ata_pkg::CORDIC_STAGES_DEF < ATAN_ENTRIES) ?
                                      ata_pkg::CORDIC_STAGES_DEF : ATAN_ENTRIES;
   localparam longint PITCH_BOUND   = 90 * 128;
   localparam longint ROLL_BOUND    = 180 * 128;
   localparam longint HALF_TURN_Q16 = 180 * 65536;
   localparam longint IN_SCALE      = 4096;
   localparam int    PIPE_LATENCY   = ata_pkg::CORDIC_STAGES_DEF + 33;
   localparam int    RANDOM_ITEMS   = 450;
   localparam int    MAX_WAIT       = 18;
   localparam int    LONG_HOLD      = 300;
   localparam int    HOLD_AFTER     = 100;
   localparam int    DRAIN_AT       = 250;
   localparam int    WATCHDOG_LIMIT = 3000;

   typedef struct {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
      int                     gap;
      bit                     drain_first;
   } sample_type;

   typedef struct {
      logic signed [PITCH_W-1:0] pitch;
      logic signed [ROLL_W-1:0]  roll;
   } angles_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [IN_W-1:0]    req_accel_x = '0;
   logic signed [IN_W-1:0]    req_accel_y = '0;
   logic signed [IN_W-1:0]    req_accel_z = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [PITCH_W-1:0] rsp_pitch_angle;
   logic signed [ROLL_W-1:0]  rsp_roll_angle;

   // atan(2^-i) in degrees, scaled by 2^16 and rounded to nearest.
   longint atan_deg_q16 [0:ATAN_ENTRIES-1] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   sample_type sample_queue [$];
   angles_type pending_angles [$];

   logic req_taken   = 1'b0;
   logic rsp_taken   = 1'b0;
   logic long_hold   = 1'b0;
   int   fail_count  = 0;
   int   results_seen = 0;
   int   idle_cycles = 0;
   int   gap_count   = 0;
   int   hold_left   = 0;
   int   stall_left  = 0;
   bit   hold_done   = 1'b0;
   bit   calm_receiver = 1'b0;

   accel_tilt_angles u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_roll_angle  (rsp_roll_angle)
   );

   initial forever #10 clock = ~clock;

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   function automatic longint unsigned floor_root(input longint unsigned value);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned probe;
      rem   = value;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Vectoring CORDIC: angle of (den, num) in 1/128 degree, saturated.
   function automatic longint cordic_atan2(input longint num, input longint den,
                                           input longint bound);
      longint xv;
      longint yv;
      longint acc;
      longint dx;
      longint dy;
      longint r;
      int     stage;
      if (num == 0) begin
         return (den < 0) ? -bound : 0;
      end
      xv  = den;
      yv  = num;
      acc = 0;
      // A vector in the left half plane is turned by a half turn first.
      if (xv < 0) begin
         acc = (yv > 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
         xv  = -xv;
         yv  = -yv;
      end
      for (stage = 0; stage < ROTATIONS; stage++) begin
         dx = yv >>> stage;
         dy = xv >>> stage;
         if (yv >= 0) begin
            xv  = xv + dx;
            yv  = yv - dy;
            acc = acc + atan_deg_q16[stage];
         end else begin
            xv  = xv - dx;
            yv  = yv + dy;
            acc = acc - atan_deg_q16[stage];
         end
      end
      r = (acc + 256) >>> 9;
      if (r > bound) r = bound;
      if (r < -bound) r = -bound;
      return r;
   endfunction

   function automatic angles_type predict_tilt(input logic signed [IN_W-1:0] x,
                                               input logic signed [IN_W-1:0] y,
                                               input logic signed [IN_W-1:0] z);
      longint          ax;
      longint          ay;
      longint          az;
      longint          horiz;
      longint          pitch_full;
      longint          roll_full;
      longint unsigned sumsq;
      angles_type      angles;
      ax         = x;
      ay         = y;
      az         = z;
      sumsq      = ax * ax + az * az;
      horiz      = floor_root(sumsq << 24);
      pitch_full = cordic_atan2(ay * IN_SCALE, horiz, PITCH_BOUND);
      roll_full  = cordic_atan2(-ax * IN_SCALE, az * IN_SCALE, ROLL_BOUND);
      angles.pitch = pitch_full[PITCH_W-1:0];
      angles.roll  = roll_full[ROLL_W-1:0];
      return angles;
   endfunction

   task automatic add_sample(input logic signed [IN_W-1:0] x,
                             input logic signed [IN_W-1:0] y,
                             input logic signed [IN_W-1:0] z,
                             input int gap, input bit drain_first);
      sample_type s;
      s.x           = x;
      s.y           = y;
      s.z           = z;
      s.gap         = gap;
      s.drain_first = drain_first;
      sample_queue.push_back(s);
   endtask

   function automatic logic signed [IN_W-1:0] random_axis(input int kind);
      logic signed [IN_W-1:0] v;
      case (kind)
         1:       v = IN_W'(int'($urandom_range(0, 34000)) - 17000);
         2:       v = IN_W'(int'($urandom_range(0, 16)) - 8);
         3: begin
            case ($urandom_range(0, 4))
               0:       v = 16'sh8000;
               1:       v = 16'sh7fff;
               2:       v = 16'sd0;
               3:       v = -16'sd1;
               default: v = 16'sd1;
            endcase
         end
         default: v = IN_W'($urandom);
      endcase
      return v;
   endfunction

   // Stimulus: directed corners first, then random samples of mixed shape.
   initial begin
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
      int  kind;
      int  gap;
      bit  quiet_sender;

      add_sample(16'sd0, 16'sd0, 16'sd0, $urandom_range(0, MAX_WAIT), 1'b0);
      add_sample(16'sd0, 16'sd0, 16'sd16384, $urandom_range(0, MAX_WAIT), 1'b0);
      add_sample(16'sd0, 16'sd0, -16'sd16384, $urandom_range(0, MAX_WAIT), 1'b0);
      add_sample(16'sd0, 16'sd16384, 16'sd0, $urandom_range(0, MAX_WAIT), 1'b0);
      add_sample(16'sd0, -16'sd16384, 16'sd0, $urandom_range(0, MAX_WAIT), 1'b0);
      add_sample(16'sd0, 16'sh7fff, 16'sd0, 0, 1'b0);
      add_sample(16'sd0, 16'sh8000, 16'sd0, 0, 1'b0);
      add_sample(16'sd100, 16'sd0, -16'sd200, $urandom_range(0, MAX_WAIT), 1'b0);
      add_sample(-16'sd100, 16'sd0, -16'sd200, $urandom_range(0, MAX_WAIT), 1'b0);
      add_sample(16'sd16384, 16'sd0, 16'sd0, 0, 1'b0);
      add_sample(-16'sd16384, 16'sd0, 16'sd0, 0, 1'b0);
      add_sample(16'sh8000, 16'sh8000, 16'sh8000, $urandom_range(0, MAX_WAIT), 1'b0);
      add_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 1'b0);
      add_sample(16'sh8000, 16'sh7fff, 16'sh8000, 0, 1'b0);
      add_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 0, 1'b0);
      add_sample(16'sh8000, 16'sd0, 16'sd0, $urandom_range(0, MAX_WAIT), 1'b0);
      add_sample(16'sd0, 16'sd0, 16'sh8000, 0, 1'b0);
      add_sample(16'sd1, 16'sd0, -16'sd1, 0, 1'b0);
      add_sample(-16'sd1, 16'sd0, -16'sd1, $urandom_range(0, MAX_WAIT), 1'b0);
      add_sample(16'sd1, 16'sd1, 16'sd1, 0, 1'b0);
      add_sample(-16'sd1, -16'sd1, -16'sd1, 0, 1'b0);
      add_sample(16'sd0, 16'sd1, 16'sd0, $urandom_range(0, MAX_WAIT), 1'b0);
      add_sample(16'sd0, -16'sd1, 16'sd0, 0, 1'b0);
      add_sample(16'sd3, -16'sd7, 16'sh8000, 0, 1'b0);

      quiet_sender = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         case (kind)
            4, 5: begin
               x = random_axis(1);
               y = random_axis(1);
               z = random_axis(1);
            end
            6: begin
               x = random_axis(2);
               y = random_axis(2);
               z = random_axis(2);
            end
            7: begin
               x = random_axis(0);
               y = random_axis(0);
               z = random_axis(0);
               case ($urandom_range(0, 2))
                  0:       x = '0;
                  1:       y = '0;
                  default: z = '0;
               endcase
            end
            8: begin
               // Zero x exercises the roll axis on the +-180 and 0 boundary.
               x = '0;
               y = random_axis(0);
               z = random_axis(0);
            end
            9: begin
               x = random_axis(3);
               y = random_axis(3);
               z = random_axis(3);
            end
            default: begin
               x = random_axis(0);
               y = random_axis(0);
               z = random_axis(0);
            end
         endcase
         gap = quiet_sender ? 0 : $urandom_range(0, MAX_WAIT);
         add_sample(x, y, z, gap, n == DRAIN_AT);
      end

      while (sample_queue.size() != 0 || req_valid) @(posedge clock);
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && pending_angles.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Sender: one beat offered at a time, held until it is accepted.
   always @(negedge clock) begin
      sample_type next_item;
      logic       offer;
      offer = req_valid && !req_taken;
      if (!reset && !offer && sample_queue.size() != 0) begin
         if (gap_count < sample_queue[0].gap && !long_hold) begin
            gap_count = gap_count + 1;
         end else if (!(sample_queue[0].drain_first && pending_angles.size() != 0)) begin
            next_item = sample_queue.pop_front();
            req_accel_x <= next_item.x;
            req_accel_y <= next_item.y;
            req_accel_z <= next_item.z;
            offer     = 1'b1;
            gap_count = 0;
         end
      end
      req_valid <= offer;
   end

   // Receiver: a random stall per result, plus one long hold-off that lets
   // the pipeline fill up and push back on the sender.
   always @(negedge clock) begin
      logic next_stall;
      next_stall = 1'b0;
      if (!reset) begin
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (rsp_taken) begin
            if (results_seen % 40 == 0) calm_receiver = ($urandom_range(0, 3) == 0);
            stall_left = calm_receiver ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            next_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            next_stall = 1'b1;
         end
      end
      rsp_stall <= next_stall;
      long_hold <= (hold_left > 0);
   end

   // Monitor: predict on every accepted request beat, check every result beat.
   always @(posedge clock) begin
      angles_type expected;
      logic       req_fire;
      logic       rsp_fire;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (req_fire) begin
         pending_angles.push_back(predict_tilt(req_accel_x, req_accel_y, req_accel_z));
      end
      if (rsp_fire) begin
         results_seen = results_seen + 1;
         if (pending_angles.size() == 0) begin
            $error("rsp beat with no expected angles: pitch %0d roll %0d",
                   rsp_pitch_angle, rsp_roll_angle);
            fail_count = fail_count + 1;
         end else begin
            expected = pending_angles.pop_front();
            if (rsp_pitch_angle !== expected.pitch) begin
               $error("pitch_angle: expected %0d, actual %0d", expected.pitch,
                      rsp_pitch_angle);
               fail_count = fail_count + 1;
            end
            if (rsp_roll_angle !== expected.roll) begin
               $error("roll_angle: expected %0d, actual %0d", expected.roll,
                      rsp_roll_angle);
               fail_count = fail_count + 1;
            end
         end
      end
      if (reset || req_fire || rsp_fire) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      req_taken <= req_fire;
      rsp_taken <= rsp_fire;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ata_pkg.sv
rtl/ata_sqrt_cell.sv
rtl/ata_cordic_cell.sv
rtl/accel_tilt_angles.sv
rtl/ata_checker.sv
tb/testbench.sv
